[hw/rtl/haas_stereo_enhancer_assert.svh]
// ----------------------------------------------------------------------------
// haas_stereo_enhancer_assert.svh
// Assertion macros shared by the stereo enhancer RTL.
// ----------------------------------------------------------------------------
`ifndef HAAS_STEREO_ENHANCER_ASSERT_SVH
`define HAAS_STEREO_ENHANCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define HSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define HSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/hse_pkg.sv]
// ----------------------------------------------------------------------------
// hse_pkg
// Types, constants and helpers for the Haas stereo enhancer.
// ----------------------------------------------------------------------------
package hse_pkg;

  // delay store; depth is a power of two, indexes wrap by truncation
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int DELAY_W  = 12;
  localparam int SAT_W    = 36;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [2:0] REG_MID_SOURCE  = 3'd0;
  localparam logic [2:0] REG_MID_INVERT  = 3'd1;
  localparam logic [2:0] REG_BYPASS_ON   = 3'd2;
  localparam logic [2:0] REG_TAP_DELAY_A = 3'd3;
  localparam logic [2:0] REG_TAP_DELAY_B = 3'd4;
  localparam logic [2:0] REG_GAIN_IN     = 3'd5;
  localparam logic [2:0] REG_GAIN_OUT    = 3'd6;
  localparam logic [2:0] REG_SIDE_COEFFS = 3'd7;

  localparam logic [1:0] MID_LEFT     = 2'd0;
  localparam logic [1:0] MID_RIGHT    = 2'd1;
  localparam logic [1:0] MID_HALF_SUM = 2'd2;
  localparam logic [1:0] MID_HALF_DIF = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [1:0]          mid_source;
    logic                mid_invert;
    logic                bypass_on;
    logic [DELAY_W-1:0]  tap_delay_a;
    logic [DELAY_W-1:0]  tap_delay_b;
    logic [GAIN_W-1:0]   gain_in;
    logic [GAIN_W-1:0]   gain_out;
    logic [4*COEF_W-1:0] side_coeffs;
  } cfg_t;

  function automatic sample_t sat24(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(8388607);
    lo = -SAT_W'(8388608);
    if (x > hi) begin
      return sample_t'(hi);
    end else if (x < lo) begin
      return sample_t'(lo);
    end else begin
      return sample_t'(x);
    end
  endfunction

endpackage

[hw/rtl/hse_regs.sv]
// ----------------------------------------------------------------------------
// hse_regs
// APB register file holding the enhancer configuration.
// ----------------------------------------------------------------------------
module hse_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hse_pkg::PADDR_W-1:0] paddr,
  input  logic [hse_pkg::PDATA_W-1:0] pwdata,
  output logic [hse_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output hse_pkg::cfg_t               cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[5:3];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mid_source  <= hse_pkg::MID_HALF_SUM;
      cfg.mid_invert  <= 1'b0;
      cfg.bypass_on   <= 1'b0;
      cfg.tap_delay_a <= '0;
      cfg.tap_delay_b <= '0;
      cfg.gain_in     <= hse_pkg::GAIN_UNITY;
      cfg.gain_out    <= hse_pkg::GAIN_UNITY;
      cfg.side_coeffs <= '0;
    end else if (wr_en) begin
      unique case (reg_index)
        hse_pkg::REG_MID_SOURCE:  cfg.mid_source  <= pwdata[1:0];
        hse_pkg::REG_MID_INVERT:  cfg.mid_invert  <= pwdata[0];
        hse_pkg::REG_BYPASS_ON:   cfg.bypass_on   <= pwdata[0];
        hse_pkg::REG_TAP_DELAY_A: cfg.tap_delay_a <= pwdata[hse_pkg::DELAY_W-1:0];
        hse_pkg::REG_TAP_DELAY_B: cfg.tap_delay_b <= pwdata[hse_pkg::DELAY_W-1:0];
        hse_pkg::REG_GAIN_IN:     cfg.gain_in     <= pwdata[hse_pkg::GAIN_W-1:0];
        hse_pkg::REG_GAIN_OUT:    cfg.gain_out    <= pwdata[hse_pkg::GAIN_W-1:0];
        hse_pkg::REG_SIDE_COEFFS: cfg.side_coeffs <= pwdata[4*hse_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      hse_pkg::REG_MID_SOURCE:  prdata = hse_pkg::PDATA_W'(cfg.mid_source);
      hse_pkg::REG_MID_INVERT:  prdata = hse_pkg::PDATA_W'(cfg.mid_invert);
      hse_pkg::REG_BYPASS_ON:   prdata = hse_pkg::PDATA_W'(cfg.bypass_on);
      hse_pkg::REG_TAP_DELAY_A: prdata = hse_pkg::PDATA_W'(cfg.tap_delay_a);
      hse_pkg::REG_TAP_DELAY_B: prdata = hse_pkg::PDATA_W'(cfg.tap_delay_b);
      hse_pkg::REG_GAIN_IN:     prdata = hse_pkg::PDATA_W'(cfg.gain_in);
      hse_pkg::REG_GAIN_OUT:    prdata = hse_pkg::PDATA_W'(cfg.gain_out);
      hse_pkg::REG_SIDE_COEFFS: prdata = hse_pkg::PDATA_W'(cfg.side_coeffs);
      default:                  prdata = '0;
    endcase
  end

endmodule

[hw/rtl/hse_store.sv]
// ----------------------------------------------------------------------------
// hse_store
// Mid delay memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hse_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [hse_pkg::ADDR_W-1:0] wr_addr,
  input  hse_pkg::sample_t           wr_data,
  input  logic                       rd_en,
  input  logic [hse_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [hse_pkg::ADDR_W-1:0] rd_addr_b,
  output hse_pkg::sample_t           rd_data_a,
  output hse_pkg::sample_t           rd_data_b
);

  hse_pkg::sample_t mem [hse_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[hw/rtl/haas_stereo_enhancer.sv]
// ----------------------------------------------------------------------------
// haas_stereo_enhancer
// Haas stereo widener: mid into a delay memory, two taps form the sides.
// ----------------------------------------------------------------------------
// Each item steps through the sequencer from acceptance to a loaded result:
// mid select and input gain, memory write with forwarded tap read,
// coefficient products, side sums, split output-gain products, then
// rounding and saturation. The input stalls until the sequencer is back in
// idle, so a new item is taken only once the last one is loaded; a held
// result keeps the next item waiting in its last stage. A finished item sits
// in the output register while the next item is taken. Memory contents are
// not cleared after reset: a fill flag with the write index makes entries
// not yet written read as zero, so items are accepted as soon as reset ends.
`include "haas_stereo_enhancer_assert.svh"

module haas_stereo_enhancer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  hse_pkg::sample_t            left_in,
  input  hse_pkg::sample_t            right_in,
  output logic                        result_valid,
  input  logic                        result_stall,
  output hse_pkg::sample_t            left_out,
  output hse_pkg::sample_t            right_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hse_pkg::PADDR_W-1:0] paddr,
  input  logic [hse_pkg::PDATA_W-1:0] pwdata,
  output logic [hse_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MID   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_MULT  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_GAIN  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam int AW     = hse_pkg::ADDR_W;
  localparam int PROD_W = 41;
  localparam int RND_W  = 42;
  localparam int TP_W   = 40;
  localparam int ACC_W  = 42;
  localparam int HI_W   = ACC_W - 24;
  localparam int PH_W   = HI_W + hse_pkg::GAIN_W + 1;
  localparam int CRY_W  = TP_W + 1 - 24;

  hse_pkg::cfg_t cfg;

  logic [2:0] state;
  logic       accept;
  logic       load_out;

  hse_pkg::sample_t l_q, r_q;
  hse_pkg::sample_t mid;
  logic signed [hse_pkg::SAMPLE_W:0] sum25, dif25;
  logic signed [PROD_W-1:0] prod_c, prod_mid;
  logic signed [RND_W-1:0]  rnd;
  logic signed [29:0]       rnd_sh;
  hse_pkg::sample_t stored_val, stored;

  logic [AW-1:0] write_index;
  logic          full;
  logic [AW-1:0] tap_a, tap_b;
  logic          fwd_a, fwd_b, ok_a, ok_b;
  hse_pkg::sample_t rd_a, rd_b, t0, t1;

  logic signed [hse_pkg::COEF_W-1:0] a0, a1, b0, b1;
  logic signed [TP_W-1:0]  pa0, pa1, pb0, pb1;
  logic signed [hse_pkg::SAMPLE_W:0] m_q;
  logic signed [ACC_W-1:0] accl, accr;
  logic [TP_W-1:0]         pl_l, pl_r;
  logic signed [PH_W-1:0]  ph_l, ph_r;
  logic signed [hse_pkg::GAIN_W:0] g_s;
  logic signed [HI_W-1:0]  hi_l, hi_r;
  logic [TP_W:0]           rl_l, rl_r;
  logic signed [hse_pkg::SAT_W-1:0] ow_l, ow_r;

  hse_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hse_store u_store (
    .clk       (clk),
    .wr_en     (state == ST_STORE),
    .wr_addr   (write_index),
    .wr_data   (stored_val),
    .rd_en     (state == ST_MID),
    .rd_addr_a (tap_a),
    .rd_addr_b (tap_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign load_out     = (state == ST_OUT) && (!result_valid || !result_stall);

  // mid select, floor halving drops the lsb
  assign sum25 = (hse_pkg::SAMPLE_W+1)'(l_q) + (hse_pkg::SAMPLE_W+1)'(r_q);
  assign dif25 = (hse_pkg::SAMPLE_W+1)'(l_q) - (hse_pkg::SAMPLE_W+1)'(r_q);

  always_comb begin
    unique case (cfg.mid_source)
      hse_pkg::MID_LEFT:     mid = l_q;
      hse_pkg::MID_RIGHT:    mid = r_q;
      hse_pkg::MID_HALF_SUM: mid = sum25[hse_pkg::SAMPLE_W:1];
      hse_pkg::MID_HALF_DIF: mid = dif25[hse_pkg::SAMPLE_W:1];
      default:               mid = l_q;
    endcase
  end

  assign prod_c     = mid * $signed({1'b0, cfg.gain_in});
  assign rnd        = RND_W'(prod_mid) + RND_W'(2048);
  assign rnd_sh     = rnd[RND_W-1:12];
  assign stored_val = hse_pkg::sat24(hse_pkg::SAT_W'(rnd_sh));

  assign tap_a = write_index - AW'(cfg.tap_delay_a);
  assign tap_b = write_index - AW'(cfg.tap_delay_b);

  assign a0 = cfg.side_coeffs[15:0];
  assign a1 = cfg.side_coeffs[31:16];
  assign b0 = cfg.side_coeffs[47:32];
  assign b1 = cfg.side_coeffs[63:48];

  assign g_s  = $signed({1'b0, cfg.gain_out});
  assign hi_l = accl[ACC_W-1:24];
  assign hi_r = accr[ACC_W-1:24];

  // low partial product rounded; carry joins the high partial product
  assign rl_l = {1'b0, pl_l} + (TP_W+1)'(8388608);
  assign rl_r = {1'b0, pl_r} + (TP_W+1)'(8388608);
  assign ow_l = hse_pkg::SAT_W'(ph_l)
              + $signed({(hse_pkg::SAT_W-CRY_W)'(0), rl_l[TP_W:24]});
  assign ow_r = hse_pkg::SAT_W'(ph_r)
              + $signed({(hse_pkg::SAT_W-CRY_W)'(0), rl_r[TP_W:24]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_index <= '0;
      full        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE:  if (accept) state <= ST_MID;
        ST_MID:   state <= ST_STORE;
        ST_STORE: begin
          state       <= ST_MULT;
          write_index <= write_index + 1'b1;
          if (write_index == AW'(hse_pkg::STORE_DEPTH - 1)) full <= 1'b1;
        end
        ST_MULT:  state <= ST_SUM;
        ST_SUM:   state <= ST_GAIN;
        ST_GAIN:  state <= ST_OUT;
        ST_OUT:   if (load_out) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      l_q <= left_in;
      r_q <= right_in;
    end
    if (state == ST_MID) begin
      prod_mid <= prod_c;
      fwd_a    <= (tap_a == write_index);
      fwd_b    <= (tap_b == write_index);
      ok_a     <= full || (tap_a < write_index);
      ok_b     <= full || (tap_b < write_index);
    end
    if (state == ST_STORE) begin
      stored <= stored_val;
      t0     <= fwd_a ? stored_val : (ok_a ? rd_a : '0);
      t1     <= fwd_b ? stored_val : (ok_b ? rd_b : '0);
    end
    if (state == ST_MULT) begin
      pa0 <= a0 * t0;
      pa1 <= a1 * t1;
      pb0 <= b0 * t0;
      pb1 <= b1 * t1;
      m_q <= cfg.mid_invert ? -(hse_pkg::SAMPLE_W+1)'(stored)
                            : (hse_pkg::SAMPLE_W+1)'(stored);
    end
    if (state == ST_SUM) begin
      accl <= (ACC_W'(m_q) <<< 12) + ACC_W'(pa0) - ACC_W'(pa1);
      accr <= (ACC_W'(m_q) <<< 12) + ACC_W'(pb1) - ACC_W'(pb0);
    end
    if (state == ST_GAIN) begin
      pl_l <= accl[23:0] * cfg.gain_out;
      pl_r <= accr[23:0] * cfg.gain_out;
      ph_l <= hi_l * g_s;
      ph_r <= hi_r * g_s;
    end
    if (load_out) begin
      left_out  <= cfg.bypass_on ? l_q : hse_pkg::sat24(ow_l);
      right_out <= cfg.bypass_on ? r_q : hse_pkg::sat24(ow_r);
    end
  end

  `HSE_ASSERT_NEXT(a_accept_mid, accept, state == ST_MID, "accepted item did not start")
  `HSE_ASSERT_NEXT(a_index_step, state == ST_STORE, write_index == AW'($past(write_index) + 1'b1), "write index did not advance")
  `HSE_ASSERT_NEXT(a_out_hold, state == ST_OUT && result_valid && result_stall, state == ST_OUT, "result overwritten while held")
  `HSE_ASSERT_IMP(a_full_wrap, $rose(full), write_index == '0, "fill flag set off the wrap")

endmodule

[tb/sv/haas_stereo_enhancer_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haas_stereo_enhancer_check
// Watches the sample, result and register ports of the stereo enhancer. Keeps
// its own copy of the registers, the delay memory and the write pointer,
// works out the output pair of every accepted sample and compares each
// accepted result with the oldest pair still waiting.
// ----------------------------------------------------------------------------
module haas_stereo_enhancer_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  input  logic                        sample_stall,
  input  hse_pkg::sample_t            left_in,
  input  hse_pkg::sample_t            right_in,
  input  logic                        result_valid,
  input  logic                        result_stall,
  input  hse_pkg::sample_t            left_out,
  input  hse_pkg::sample_t            right_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [hse_pkg::PADDR_W-1:0] paddr,
  input  logic [hse_pkg::PDATA_W-1:0] pwdata,
  output int                          mismatches,
  output int                          outstanding
);

  typedef struct {
    hse_pkg::sample_t left;
    hse_pkg::sample_t right;
  } stereo_t;

  hse_pkg::cfg_t              cfg;
  hse_pkg::sample_t           mid_mem [hse_pkg::STORE_DEPTH];
  logic [hse_pkg::ADDR_W-1:0] wr_ptr;
  stereo_t                    pending_outputs [$];
  int                         fail_count;
  int                         results_seen;

  function automatic hse_pkg::sample_t clamp24(input longint x);
    if (x > 64'sd8388607) begin
      return hse_pkg::sample_t'(24'sh7FFFFF);
    end else if (x < -64'sd8388608) begin
      return hse_pkg::sample_t'(24'sh800000);
    end
    return hse_pkg::sample_t'(x);
  endfunction

  // one sample through the widener; updates memory and write pointer
  function automatic stereo_t widen_sample(input hse_pkg::sample_t l,
                                           input hse_pkg::sample_t r);
    longint                     mid;
    longint                     stored;
    longint                     t0;
    longint                     t1;
    longint                     a0;
    longint                     a1;
    longint                     b0;
    longint                     b1;
    longint                     m;
    longint                     g;
    longint                     acc_l;
    longint                     acc_r;
    logic [hse_pkg::ADDR_W-1:0] tap0;
    logic [hse_pkg::ADDR_W-1:0] tap1;
    stereo_t                    y;
    case (cfg.mid_source)
      hse_pkg::MID_LEFT:     mid = l;
      hse_pkg::MID_RIGHT:    mid = r;
      hse_pkg::MID_HALF_SUM: mid = (longint'(l) + longint'(r)) >>> 1;
      default:               mid = (longint'(l) - longint'(r)) >>> 1;
    endcase
    stored = clamp24((mid * longint'(cfg.gain_in) + 64'sd2048) >>> 12);
    mid_mem[wr_ptr] = hse_pkg::sample_t'(stored);
    if (cfg.bypass_on) begin
      y.left  = l;
      y.right = r;
    end else begin
      tap0  = wr_ptr - cfg.tap_delay_a;
      tap1  = wr_ptr - cfg.tap_delay_b;
      t0    = mid_mem[tap0];
      t1    = mid_mem[tap1];
      a0    = longint'($signed(cfg.side_coeffs[15:0]));
      a1    = longint'($signed(cfg.side_coeffs[31:16]));
      b0    = longint'($signed(cfg.side_coeffs[47:32]));
      b1    = longint'($signed(cfg.side_coeffs[63:48]));
      m     = cfg.mid_invert ? -stored : stored;
      g     = longint'(cfg.gain_out);
      acc_l = m * 4096 + a0 * t0 - a1 * t1;
      acc_r = m * 4096 + b1 * t1 - b0 * t0;
      y.left  = clamp24((acc_l * g + (64'sd1 << 23)) >>> 24);
      y.right = clamp24((acc_r * g + (64'sd1 << 23)) >>> 24);
    end
    wr_ptr = wr_ptr + 1'b1;
    return y;
  endfunction

  always @(posedge clk) begin : monitor
    stereo_t want;
    if (rst) begin
      foreach (mid_mem[i]) mid_mem[i] = '0;
      wr_ptr          = '0;
      cfg.mid_source  = hse_pkg::MID_HALF_SUM;
      cfg.mid_invert  = 1'b0;
      cfg.bypass_on   = 1'b0;
      cfg.tap_delay_a = '0;
      cfg.tap_delay_b = '0;
      cfg.gain_in     = hse_pkg::GAIN_UNITY;
      cfg.gain_out    = hse_pkg::GAIN_UNITY;
      cfg.side_coeffs = '0;
      pending_outputs.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[hse_pkg::PADDR_W-1:3])
          hse_pkg::REG_MID_SOURCE:  cfg.mid_source  = pwdata[1:0];
          hse_pkg::REG_MID_INVERT:  cfg.mid_invert  = pwdata[0];
          hse_pkg::REG_BYPASS_ON:   cfg.bypass_on   = pwdata[0];
          hse_pkg::REG_TAP_DELAY_A: cfg.tap_delay_a = pwdata[hse_pkg::DELAY_W-1:0];
          hse_pkg::REG_TAP_DELAY_B: cfg.tap_delay_b = pwdata[hse_pkg::DELAY_W-1:0];
          hse_pkg::REG_GAIN_IN:     cfg.gain_in     = pwdata[hse_pkg::GAIN_W-1:0];
          hse_pkg::REG_GAIN_OUT:    cfg.gain_out    = pwdata[hse_pkg::GAIN_W-1:0];
          hse_pkg::REG_SIDE_COEFFS: cfg.side_coeffs = pwdata[4*hse_pkg::COEF_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (pending_outputs.size() == 0) begin
          if (fail_count < 10) begin
            $display("result %0d: no item pending, got left %0d right %0d",
                     results_seen, left_out, right_out);
          end
          fail_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (want.left !== left_out || want.right !== right_out) begin
            if (fail_count < 10) begin
              $display("result %0d: left exp %0d got %0d, right exp %0d got %0d",
                       results_seen, want.left, left_out, want.right, right_out);
            end
            fail_count++;
          end
        end
        results_seen++;
      end
      if (sample_valid && !sample_stall) begin
        pending_outputs.push_back(widen_sample(left_in, right_in));
      end
    end
    mismatches  <= fail_count;
    outstanding <= pending_outputs.size();
  end

endmodule

[tb/sv/haas_stereo_enhancer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haas_stereo_enhancer_tb
// Drives stereo samples and register writes into the stereo enhancer: a
// directed set of extreme samples under every mid source, inversion, bypass
// and extreme gains, delays and coefficients, then random register settings
// with random samples, and a longer stream under one random setting. The
// checker next to the block predicts and compares every result.
// ----------------------------------------------------------------------------
module haas_stereo_enhancer_tb;

  localparam hse_pkg::sample_t S_MAX = 24'sh7FFFFF;
  localparam hse_pkg::sample_t S_MIN = 24'sh800000;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        sample_valid = 1'b0;
  hse_pkg::sample_t            left_in      = '0;
  hse_pkg::sample_t            right_in     = '0;
  logic                        result_stall = 1'b0;
  logic                        psel         = 1'b0;
  logic                        penable      = 1'b0;
  logic                        pwrite       = 1'b0;
  logic [hse_pkg::PADDR_W-1:0] paddr        = '0;
  logic [hse_pkg::PDATA_W-1:0] pwdata       = '0;
  logic                        sample_stall;
  logic                        result_valid;
  hse_pkg::sample_t            left_out;
  hse_pkg::sample_t            right_out;
  logic [hse_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  int                          mismatches;
  int                          outstanding;
  int                          send_idle_pct = 0;
  int                          recv_idle_pct = 0;
  int                          items_sent    = 0;

  haas_stereo_enhancer dut (.*);

  haas_stereo_enhancer_check checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(input hse_pkg::sample_t l, input hse_pkg::sample_t r);
    if (items_sent < 200) begin
      send_idle_pct = 33;
      recv_idle_pct = 68;
    end else if (items_sent < 400) begin
      send_idle_pct = 68;
      recv_idle_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    left_in      <= l;
    right_in     <= r;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    items_sent++;
  endtask

  // drain every pending result, then let the pipeline go quiet
  task automatic settle_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // writes all registers; narrow ones sometimes carry junk above their width
  task automatic program_all(input hse_pkg::cfg_t c);
    logic [2:0]  idx;
    logic [63:0] noise;
    logic [63:0] val;
    int          i;
    settle_idle();
    for (i = 0; i < 8; i++) begin
      idx   = i[2:0];
      noise = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
      case (idx)
        hse_pkg::REG_MID_SOURCE:  val = {noise[63:2], c.mid_source};
        hse_pkg::REG_MID_INVERT:  val = {noise[63:1], c.mid_invert};
        hse_pkg::REG_BYPASS_ON:   val = {noise[63:1], c.bypass_on};
        hse_pkg::REG_TAP_DELAY_A: val = {noise[63:hse_pkg::DELAY_W], c.tap_delay_a};
        hse_pkg::REG_TAP_DELAY_B: val = {noise[63:hse_pkg::DELAY_W], c.tap_delay_b};
        hse_pkg::REG_GAIN_IN:     val = {noise[63:hse_pkg::GAIN_W], c.gain_in};
        hse_pkg::REG_GAIN_OUT:    val = {noise[63:hse_pkg::GAIN_W], c.gain_out};
        default:                  val = c.side_coeffs;
      endcase
      apb_write(idx, val);
    end
  endtask

  function automatic hse_pkg::sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return hse_pkg::sample_t'($urandom_range(0, 2000) - 1000);
      default: return hse_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [hse_pkg::DELAY_W-1:0] rand_delay();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return hse_pkg::DELAY_W'($urandom_range(0, 4095));
      default: return hse_pkg::DELAY_W'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [hse_pkg::GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return hse_pkg::GAIN_W'($urandom);
      default: return hse_pkg::GAIN_W'($urandom_range(1024, 8192));
    endcase
  endfunction

  function automatic logic [hse_pkg::COEF_W-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return hse_pkg::COEF_W'($urandom);
      default: return hse_pkg::COEF_W'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  function automatic hse_pkg::cfg_t rand_config(input bit allow_bypass);
    hse_pkg::cfg_t c;
    int            i;
    c.mid_source  = 2'($urandom_range(0, 3));
    c.mid_invert  = 1'($urandom_range(0, 1));
    c.bypass_on   = allow_bypass && ($urandom_range(0, 5) == 0);
    c.tap_delay_a = rand_delay();
    c.tap_delay_b = rand_delay();
    c.gain_in     = rand_gain();
    c.gain_out    = rand_gain();
    for (i = 0; i < 4; i++) begin
      c.side_coeffs[hse_pkg::COEF_W*i +: hse_pkg::COEF_W] = rand_coeff();
    end
    return c;
  endfunction

  initial begin : stimulus
    hse_pkg::cfg_t c;
    int            k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: half sum, unity gains, no side
    send_item(S_MAX, S_MAX);
    send_item(S_MIN, S_MIN);
    send_item(S_MAX, S_MIN);
    send_item(S_MIN, S_MAX);
    send_item('0, '0);
    send_item(-24'sd1, -24'sd1);

    // left source, inverted, full gains, extreme coefficients
    c.mid_source  = hse_pkg::MID_LEFT;
    c.mid_invert  = 1'b1;
    c.bypass_on   = 1'b0;
    c.tap_delay_a = '0;
    c.tap_delay_b = 12'd1;
    c.gain_in     = '1;
    c.gain_out    = '1;
    c.side_coeffs = {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
    program_all(c);
    send_item(S_MAX, '0);
    send_item(S_MIN, '0);
    send_item(24'sd1, -24'sd1);
    send_item(-24'sd1, 24'sd1);
    send_item('0, S_MAX);

    // right source, longest delay hits never-written entries, tiny input gain
    c.mid_source  = hse_pkg::MID_RIGHT;
    c.mid_invert  = 1'b0;
    c.tap_delay_a = '1;
    c.tap_delay_b = 12'd2;
    c.gain_in     = 16'd1;
    c.gain_out    = hse_pkg::GAIN_UNITY;
    c.side_coeffs = {4{16'h1000}};
    program_all(c);
    send_item(S_MAX, S_MAX);
    send_item(S_MIN, S_MIN);
    send_item('0, 24'sd2047);
    send_item('0, -24'sd2049);

    // half difference, tiny output gain
    c.mid_source  = hse_pkg::MID_HALF_DIF;
    c.tap_delay_a = 12'd3;
    c.tap_delay_b = 12'd5;
    c.gain_in     = hse_pkg::GAIN_UNITY;
    c.gain_out    = 16'd1;
    c.side_coeffs = {16'hF000, 16'h0800, 16'hFC00, 16'h2000};
    program_all(c);
    send_item(S_MAX, S_MIN);
    send_item(S_MIN, S_MAX);
    send_item(-24'sd1, '0);
    send_item('0, -24'sd1);

    // bypass still writes the delay memory
    c.bypass_on = 1'b1;
    program_all(c);
    send_item(S_MAX, S_MIN);
    send_item(S_MIN, S_MAX);
    send_item(24'sd123, -24'sd456);

    for (k = 0; k < 12; k++) begin
      program_all(rand_config(1'b1));
      repeat (40) send_item(rand_sample(), rand_sample());
    end

    // longer stream under one setting
    program_all(rand_config(1'b0));
    repeat (100) send_item(rand_sample(), rand_sample());

    settle_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
